>>> src/flb_pkg.sv
// Shared constants for the queue/stack buffer: command and status codes,
// controller states and parameter defaults. No dependencies.
package flb_pkg;

  localparam int DEPTH_DEFAULT = 8;
  localparam int WORD_W        = 32;

  // Command codes
  localparam logic [1:0] CMD_PUSH = 2'd0;
  localparam logic [1:0] CMD_POP  = 2'd1;
  localparam logic [1:0] CMD_SHOW = 2'd2;

  // Result status codes
  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_FULL  = 2'd1;
  localparam logic [1:0] STS_EMPTY = 2'd2;

  // Controller states
  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_t;

endpackage

>>> src/flb_mem.sv
// Entry storage: one write port, one read port with registered read data.
// Depends on flb_pkg for the word width.
module flb_mem
  import flb_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WORD_W-1:0]        wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WORD_W-1:0]        rd_data
);

  logic [WORD_W-1:0] mem [DEPTH];

  // Write a pushed word
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> src/flb_ctrl.sv
// Controller: ring pointers, command decode, read sequencer and result register.
// Depends on flb_pkg; drives the ports of flb_mem.
module flb_ctrl
  import flb_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic                       cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 cmd,
  input  logic signed [WORD_W-1:0]   push_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 status,
  output logic signed [WORD_W-1:0]   data_value,
  output logic                       last,
  output logic                       mem_wr_en,
  output logic [$clog2(DEPTH)-1:0]   mem_wr_addr,
  output logic [WORD_W-1:0]          mem_wr_data,
  output logic                       mem_rd_en,
  output logic [$clog2(DEPTH)-1:0]   mem_rd_addr,
  input  logic [WORD_W-1:0]          mem_rd_data
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  // Fold a sum below twice the depth back into the ring
  function automatic logic [IDX_W-1:0] wrap(input logic [SUM_W-1:0] s);
    logic [SUM_W-1:0] r;
    r = (s >= SUM_W'(DEPTH)) ? (s - SUM_W'(DEPTH)) : s;
    return r[IDX_W-1:0];
  endfunction

  state_t            state, state_next;
  logic              pending, pending_next;
  logic [IDX_W-1:0]  slot, slot_next;
  logic [CNT_W-1:0]  remain, remain_next;
  logic              step_down, step_down_next;
  logic [IDX_W-1:0]  head, head_next;
  logic [CNT_W-1:0]  count, count_next;
  logic              order_mode;
  logic              out_valid_next;
  logic [1:0]        out_status_next;
  logic [WORD_W-1:0] out_data_next;
  logic              out_last_next;
  logic              load;
  logic              can_load;
  logic              accept;
  logic [IDX_W-1:0]  slot_step;
  logic [IDX_W-1:0]  top_slot;

  assign can_load = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // Neighbor slot in the direction of the current read run
  always_comb begin
    if (step_down) begin
      slot_step = (slot == '0) ? IDX_W'(DEPTH - 1) : slot - IDX_W'(1);
    end else begin
      slot_step = (slot == IDX_W'(DEPTH - 1)) ? '0 : slot + IDX_W'(1);
    end
  end

  // Slot of the newest entry, valid when the store is not empty
  assign top_slot = wrap(SUM_W'(head) + SUM_W'(count) - SUM_W'(1));

  // Next state, memory requests and result loading
  always_comb begin
    state_next      = state;
    pending_next    = pending;
    slot_next       = slot;
    remain_next     = remain;
    step_down_next  = step_down;
    head_next       = head;
    count_next      = count;
    out_valid_next  = out_valid && !out_ready;
    out_status_next = status;
    out_data_next   = data_value;
    out_last_next   = last;
    load            = 1'b0;
    in_ready        = 1'b0;
    mem_wr_en       = 1'b0;
    mem_wr_addr     = wrap(SUM_W'(head) + SUM_W'(count));
    mem_wr_data     = push_value;
    mem_rd_en       = 1'b0;
    mem_rd_addr     = slot;

    case (state)
      S_IDLE: begin
        in_ready = can_load;
        if (accept) begin
          case (cmd)
            CMD_PUSH: begin
              load          = 1'b1;
              out_last_next = 1'b1;
              if (count == CNT_W'(DEPTH)) begin
                out_status_next = STS_FULL;
                out_data_next   = '0;
              end else begin
                mem_wr_en       = 1'b1;
                count_next      = count + CNT_W'(1);
                out_status_next = STS_OK;
                out_data_next   = push_value;
              end
            end
            CMD_POP, CMD_SHOW: begin
              if (count == '0) begin
                load            = 1'b1;
                out_status_next = STS_EMPTY;
                out_data_next   = '0;
                out_last_next   = 1'b1;
              end else begin
                state_next     = S_RUN;
                pending_next   = 1'b0;
                slot_next      = order_mode ? top_slot : head;
                step_down_next = order_mode;
                if (cmd == CMD_POP) begin
                  remain_next = CNT_W'(1);
                  count_next  = count - CNT_W'(1);
                  if (!order_mode) begin
                    head_next = (head == IDX_W'(DEPTH - 1)) ? '0 : head + IDX_W'(1);
                  end
                end else begin
                  remain_next = count;
                end
              end
            end
            default: begin
              // unused command: drop
            end
          endcase
        end
      end

      S_RUN: begin
        if (!pending || can_load) begin
          if (pending) begin
            load            = 1'b1;
            out_status_next = STS_OK;
            out_data_next   = mem_rd_data;
            out_last_next   = (remain == '0);
          end
          if (remain == '0) begin
            pending_next = 1'b0;
            state_next   = S_IDLE;
          end else begin
            // issue the next read of the run
            mem_rd_en    = 1'b1;
            slot_next    = slot_step;
            remain_next  = remain - CNT_W'(1);
            pending_next = 1'b1;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (load) begin
      out_valid_next = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pending    <= 1'b0;
      remain     <= '0;
      step_down  <= 1'b0;
      head       <= '0;
      count      <= '0;
      order_mode <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state     <= state_next;
      pending   <= pending_next;
      remain    <= remain_next;
      step_down <= step_down_next;
      head      <= head_next;
      count     <= count_next;
      out_valid <= out_valid_next;
      if (cfg_we) begin
        order_mode <= cfg_wdata;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    slot       <= slot_next;
    status     <= out_status_next;
    data_value <= out_data_next;
    last       <= out_last_next;
  end

  // Fill level stays within the store
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count beyond depth");

  // No request is taken while a read run is in flight
  a_run_blocks: assert property (@(posedge clk) disable iff (rst)
    state == S_RUN |-> !in_ready)
    else $error("request accepted during read run");

  // A push into a store with room grows it by one
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd == CMD_PUSH && count != CNT_W'(DEPTH))
      |=> count == $past(count) + CNT_W'(1))
    else $error("push did not advance count");

  // A held read result keeps its memory read port quiet
  a_hold_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN && pending && !can_load) |-> !mem_rd_en)
    else $error("read issued over unconsumed data");

  // No read is left pending while the controller is idle
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !pending)
    else $error("pending read left in idle");

endmodule

>>> src/fifo_lifo_buffer.sv
// Holds up to DEPTH signed 32-bit words in a ring and serves them as a
// first-in-first-out queue (order_mode 0) or a last-in-first-out stack
// (order_mode 1). A push answers from the idle state; a pop passes through
// request, memory read and result; a show streams every stored entry out
// of the single registered read port of the entry memory, one per cycle
// while the output is not held back by out_ready. A full push, an empty pop
// or an empty show return one result without a read. The block serves one
// request at a time; order_mode may be written only while the block is idle.
// Depends on flb_pkg, flb_ctrl and flb_mem.
module fifo_lifo_buffer
  import flb_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic                     cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               cmd,
  input  logic signed [WORD_W-1:0] push_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               status,
  output logic signed [WORD_W-1:0] data_value,
  output logic                     last
);

  localparam int IDX_W = $clog2(DEPTH);

  logic              mem_wr_en;
  logic [IDX_W-1:0]  mem_wr_addr;
  logic [WORD_W-1:0] mem_wr_data;
  logic              mem_rd_en;
  logic [IDX_W-1:0]  mem_rd_addr;
  logic [WORD_W-1:0] mem_rd_data;

  // Pointers, sequencing and result register
  flb_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .push_value (push_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .data_value (data_value),
    .last       (last),
    .mem_wr_en  (mem_wr_en),
    .mem_wr_addr(mem_wr_addr),
    .mem_wr_data(mem_wr_data),
    .mem_rd_en  (mem_rd_en),
    .mem_rd_addr(mem_rd_addr),
    .mem_rd_data(mem_rd_data)
  );

  // Entry storage
  flb_mem #(
    .DEPTH(DEPTH)
  ) u_mem (
    .clk    (clk),
    .wr_en  (mem_wr_en),
    .wr_addr(mem_wr_addr),
    .wr_data(mem_wr_data),
    .rd_en  (mem_rd_en),
    .rd_addr(mem_rd_addr),
    .rd_data(mem_rd_data)
  );

endmodule
